// File: sv/link_frame_decoder_assert.svh
// Assertion macros for the link frame decoder.
// Included by the RTL files that carry concurrent checks; needs nothing else.
`ifndef LINK_FRAME_DECODER_ASSERT_SVH
`define LINK_FRAME_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define LFD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("link_frame_decoder: check failed");
`define LFD_ASSERT_NEVER(label, clk, rst_n, cond) \
    `LFD_ASSERT(label, clk, rst_n, !(cond))
`else
`define LFD_ASSERT(label, clk, rst_n, prop)
`define LFD_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: sv/lfd_pkg.sv
// Shared types, constants and the CRC-16/CCITT-FALSE byte update of the link frame decoder.
// No dependencies.
`timescale 1ns / 1ps

package lfd_pkg;

    localparam int FRAME_BYTES = 12;
    localparam int CRC_BYTES   = 10;
    localparam int COUNT_SAT   = FRAME_BYTES + 1;
    localparam int COUNT_W     = $clog2(COUNT_SAT + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // frame byte positions
    localparam logic [COUNT_W-1:0] POS_MAGIC    = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] POS_VERSION  = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] POS_KIND     = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] POS_DIR      = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] POS_BOOT_LO  = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] POS_BOOT_HI  = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] POS_SEQ_LO   = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] POS_SEQ_HI   = COUNT_W'(7);
    localparam logic [COUNT_W-1:0] POS_LANES_OK = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] POS_LANE_CNT = COUNT_W'(9);
    localparam logic [COUNT_W-1:0] POS_CRC_LO   = COUNT_W'(CRC_BYTES);
    localparam logic [COUNT_W-1:0] POS_CRC_HI   = COUNT_W'(FRAME_BYTES - 1);
    localparam logic [COUNT_W-1:0] POS_SAT      = COUNT_W'(COUNT_SAT);

    // register addresses by index
    localparam logic REG_MAGIC   = 1'b0;
    localparam logic REG_VERSION = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_LENGTH  = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_CRC     = 3'd4
    } lfd_status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } lfd_in_t;

    typedef struct packed {
        lfd_status_t       status;
        logic [7:0]        kind;
        logic signed [7:0] direction;
        logic [15:0]       boot_id;
        logic [15:0]       seq_number;
        logic [7:0]        lanes_ok;
        logic [7:0]        lane_count;
    } lfd_out_t;

    // one byte through the CRC, MSB first, eight shift steps unrolled
    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: sv/link_frame_decoder.sv
// Link frame decoder top level: byte-serial frame checker with APB register port.
// Depends on lfd_pkg and link_frame_decoder_assert.svh.
`timescale 1ns / 1ps

// Usage
//   frame channel : one received byte per request (rx_byte, frame_end flags the last
//                   byte), frame_valid / frame_stall.
//   result channel: one request per frame, issued on the last byte; status plus the
//                   decoded fields (fields read zero on any failed check).
//   APB port      : magic_byte at 0x0, version_byte at 0x4; write only while idle.
// Timing
//   A byte is taken into an input register, then folded into the CRC and the field
//   holding registers when it leaves the input register; the result register loads on
//   that same edge when the byte is the last of its frame.
//   Throughput is one byte per cycle unless a last byte waits behind a stalled result,
//   set by the unrolled 8-bit CRC update.
// Stalls
//   A held result blocks only a last byte; other bytes keep flowing. frame_stall
//   rises when a last byte waits in the input register behind a stalled result.
// Reset
//   rst_n clears the counter, check flags, valids, result and both config registers; the CRC restarts at all ones.
module link_frame_decoder
    import lfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // frame channel
    input  lfd_in_t     frame_req,
    input  logic        frame_valid,
    output logic        frame_stall,
    // result channel
    output lfd_out_t    result_req,
    output logic        result_valid,
    input  logic        result_stall,
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "link_frame_decoder_assert.svh"

    logic [7:0]         magic_byte_reg;
    logic [7:0]         version_byte_reg;

    lfd_in_t            in_req_reg;
    logic               in_valid_reg;

    logic [COUNT_W-1:0] count_reg,       count_next;
    logic [15:0]        crc_reg,         crc_next;
    logic               magic_bad_reg,   magic_bad_next;
    logic               version_bad_reg, version_bad_next;
    logic [7:0]         kind_hold_reg,   kind_hold_next;
    logic [7:0]         dir_hold_reg,    dir_hold_next;
    logic [15:0]        boot_hold_reg,   boot_hold_next;
    logic [15:0]        seq_hold_reg,    seq_hold_next;
    logic [7:0]         lanes_ok_reg,    lanes_ok_next;
    logic [7:0]         lane_cnt_reg,    lane_cnt_next;
    logic [7:0]         crc_lo_reg,      crc_lo_next;

    lfd_out_t           result_reg,      result_next;
    logic               result_valid_reg;

    logic               proc_fire;
    logic               frame_accept;
    logic               cfg_write;
    logic [7:0]         b;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_VERSION) ? {24'b0, version_byte_reg}
                                                 : {24'b0, magic_byte_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_byte_reg   <= '0;
            version_byte_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_MAGIC)
                magic_byte_reg <= pwdata[7:0];
            else
                version_byte_reg <= pwdata[7:0];
        end
    end

    // ---------------- handshake ----------------
    // a last byte needs room in the result register, other bytes always go through
    assign proc_fire    = in_valid_reg &&
                          (!in_req_reg.frame_end || !result_valid_reg || !result_stall);
    assign frame_stall  = in_valid_reg && !proc_fire;
    assign frame_accept = frame_valid && !frame_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (frame_accept)
            in_valid_reg <= 1'b1;
        else if (proc_fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (frame_accept)
            in_req_reg <= frame_req;
    end

    // ---------------- frame state update ----------------
    assign b = in_req_reg.rx_byte;

    always_comb
    begin
        count_next       = count_reg;
        crc_next         = crc_reg;
        magic_bad_next   = magic_bad_reg;
        version_bad_next = version_bad_reg;
        kind_hold_next   = kind_hold_reg;
        dir_hold_next    = dir_hold_reg;
        boot_hold_next   = boot_hold_reg;
        seq_hold_next    = seq_hold_reg;
        lanes_ok_next    = lanes_ok_reg;
        lane_cnt_next    = lane_cnt_reg;
        crc_lo_next      = crc_lo_reg;
        result_next      = '0;

        if (count_reg < POS_CRC_LO)
            crc_next = crc_byte(crc_reg, b);

        case (count_reg)
            POS_MAGIC:    magic_bad_next   = (b != magic_byte_reg);
            POS_VERSION:  version_bad_next = (b != version_byte_reg);
            POS_KIND:     kind_hold_next   = b;
            POS_DIR:      dir_hold_next    = b;
            POS_BOOT_LO:  boot_hold_next   = {boot_hold_reg[15:8], b};
            POS_BOOT_HI:  boot_hold_next   = {b, boot_hold_reg[7:0]};
            POS_SEQ_LO:   seq_hold_next    = {seq_hold_reg[15:8], b};
            POS_SEQ_HI:   seq_hold_next    = {b, seq_hold_reg[7:0]};
            POS_LANES_OK: lanes_ok_next    = b;
            POS_LANE_CNT: lane_cnt_next    = b;
            POS_CRC_LO:   crc_lo_next      = b;
            default:      ;
        endcase

        if (count_reg < POS_SAT)
            count_next = count_reg + COUNT_W'(1);

        // the high CRC byte is the last byte itself, compared straight from the input
        if (count_reg != POS_CRC_HI)
            result_next.status = ST_LENGTH;
        else if (magic_bad_reg)
            result_next.status = ST_MAGIC;
        else if (version_bad_reg)
            result_next.status = ST_VERSION;
        else if (crc_reg != {b, crc_lo_reg})
            result_next.status = ST_CRC;
        else
        begin
            result_next.status     = ST_OK;
            result_next.kind       = kind_hold_reg;
            result_next.direction  = dir_hold_reg;
            result_next.boot_id    = boot_hold_reg;
            result_next.seq_number = seq_hold_reg;
            result_next.lanes_ok   = lanes_ok_reg;
            result_next.lane_count = lane_cnt_reg;
        end

        if (in_req_reg.frame_end)
        begin
            count_next       = '0;
            crc_next         = CRC_INIT;
            magic_bad_next   = 1'b0;
            version_bad_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            crc_reg         <= CRC_INIT;
            magic_bad_reg   <= 1'b0;
            version_bad_reg <= 1'b0;
        end
        else if (proc_fire)
        begin
            count_reg       <= count_next;
            crc_reg         <= crc_next;
            magic_bad_reg   <= magic_bad_next;
            version_bad_reg <= version_bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            kind_hold_reg <= kind_hold_next;
            dir_hold_reg  <= dir_hold_next;
            boot_hold_reg <= boot_hold_next;
            seq_hold_reg  <= seq_hold_next;
            lanes_ok_reg  <= lanes_ok_next;
            lane_cnt_reg  <= lane_cnt_next;
            crc_lo_reg    <= crc_lo_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else if (proc_fire && in_req_reg.frame_end)
        begin
            result_valid_reg <= 1'b1;
            result_reg       <= result_next;
        end
        else if (result_valid_reg && !result_stall)
            result_valid_reg <= 1'b0;
    end

    assign result_valid = result_valid_reg;
    assign result_req   = result_reg;

    // ---------------- checks ----------------
    `LFD_ASSERT_NEVER(a_count_sat, clk, rst_n, count_reg > POS_SAT)
    `LFD_ASSERT(a_clear_after_end, clk, rst_n,
        (proc_fire && in_req_reg.frame_end) |=> (count_reg == '0 && crc_reg == CRC_INIT))
    `LFD_ASSERT(a_fail_fields_zero, clk, rst_n,
        (result_valid_reg && result_reg.status != ST_OK) |->
        (result_reg.kind == '0 && result_reg.boot_id == '0 && result_reg.seq_number == '0
         && result_reg.lanes_ok == '0 && result_reg.lane_count == '0
         && result_reg.direction == '0))
    `LFD_ASSERT(a_stall_cause, clk, rst_n,
        frame_stall |-> (in_req_reg.frame_end && result_valid_reg && result_stall))

endmodule
